// ===== hdl/lpnc_pkg.sv =====
// Shared types and constants for the lit palette nearest-color search block.
// Used by lpnc_ctrl, lpnc_datapath and lit_palette_nearest_color; no dependencies.
`default_nettype none

package lpnc_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
   localparam int IDX_W           = 8;
   localparam int CH_W            = 8;
   localparam int CHANNELS        = 3;
   localparam int COLOR_W         = CH_W * CHANNELS;

   // Light level and scaling
   localparam int LVL_W      = 5;
   localparam int FULL_LIGHT = 31;
   localparam int FULL_W     = 8;
   localparam int PROD_W     = CH_W + LVL_W;
   // Divide by FULL_LIGHT as a multiply by a rounded-up reciprocal
   localparam int DIV_SHIFT  = 18;
   localparam int DIV_MUL    = ((1 << DIV_SHIFT) + FULL_LIGHT - 1) / FULL_LIGHT;
   localparam int MUL_W      = PROD_W + DIV_SHIFT - 4;

   // Best distance register holds one more than the largest channel difference
   localparam int BEST_W = CH_W + 1;

   // Packed stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_RD,
      ST_BASE_MUL,
      ST_BASE_DIV,
      ST_SEARCH,
      ST_DRAIN,
      ST_DONE
   } lpnc_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic wr_en;
      logic capture;
      logic scale_mul;
      logic scale_div;
      logic search_init;
      logic search_step;
      logic rsp_load;
   } lpnc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_query;
      logic full_light;
      logic issue_last;
      logic hit;
   } lpnc_status_type;

endpackage

`default_nettype wire

// ===== hdl/lpnc_ctrl.sv =====
// Controller state machine for the lit palette nearest-color search.
// Depends on lpnc_pkg; drives lpnc_datapath through lpnc_cmd_type.
`default_nettype none

module lpnc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire lpnc_pkg::lpnc_status_type status,
   output lpnc_pkg::lpnc_cmd_type        cmd
);
   import lpnc_pkg::*;

   lpnc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && status.is_query) begin
               state_in = status.full_light ? ST_DONE : ST_BASE_RD;
            end
         end
         ST_BASE_RD:  state_in = ST_BASE_MUL;
         ST_BASE_MUL: state_in = ST_BASE_DIV;
         ST_BASE_DIV: state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (status.hit) begin
               state_in = ST_DONE;
            end else if (status.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.wr_en   = req_tvalid && !status.is_query;
            cmd.capture = req_tvalid && status.is_query;
         end
         ST_BASE_RD:  ;
         ST_BASE_MUL: cmd.scale_mul = 1'b1;
         ST_BASE_DIV: begin
            cmd.scale_div   = 1'b1;
            cmd.search_init = 1'b1;
         end
         ST_SEARCH:   cmd.search_step = !status.hit;
         ST_DRAIN:    ;
         ST_DONE:     cmd.rsp_load = rsp_free;
         default:     ;
      endcase
   end

   // Result valid: set on load, drop once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lpnc_datapath.sv =====
// Datapath: palette memory, base color scaling and the sequential nearest search.
// Depends on lpnc_pkg; controlled by lpnc_ctrl through lpnc_cmd_type.
`default_nettype none

module lpnc_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_action,
   input  wire logic [lpnc_pkg::IDX_W-1:0]  req_entry_index,
   input  wire logic [lpnc_pkg::CH_W-1:0]   req_red,
   input  wire logic [lpnc_pkg::CH_W-1:0]   req_green,
   input  wire logic [lpnc_pkg::CH_W-1:0]   req_blue,
   input  wire logic [lpnc_pkg::LVL_W-1:0]  req_light_level,
   input  wire lpnc_pkg::lpnc_cmd_type      cmd,
   output lpnc_pkg::lpnc_status_type        status,
   output logic [lpnc_pkg::IDX_W-1:0]       rsp_nearest_index
);
   import lpnc_pkg::*;

   // Palette memory, lane 0 is red
   logic [COLOR_W-1:0] pal_mem [PALETTE_ENTRIES];
   logic [COLOR_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  req_addr;

   logic [ADDR_W-1:0]  base_idx_ff;
   logic [LVL_W-1:0]   level_ff;
   logic [CHANNELS-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [CHANNELS-1:0][CH_W-1:0]   target_ff, target_in;
   logic [CHANNELS-1:0][MUL_W-1:0]  recip_prod;

   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  cmp_idx_ff;
   logic               cmp_valid_ff;
   logic [BEST_W-1:0]  best_diff_ff;
   logic [ADDR_W-1:0]  best_idx_ff;
   logic [IDX_W-1:0]   rsp_index_ff;

   logic [CHANNELS-1:0][CH_W-1:0] ch_diff;
   logic [CH_W-1:0]    max_diff;
   logic               cand_better;

   assign req_addr = req_entry_index[ADDR_W-1:0];

   // Status back to the controller
   assign status.is_query   = req_action;
   assign status.full_light = FULL_W'(req_light_level) >= FULL_W'(FULL_LIGHT);
   assign status.issue_last = addr_ff == ADDR_W'(PALETTE_ENTRIES - 1);
   assign status.hit        = best_diff_ff == '0;

   // Write on load, read every cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         pal_mem[req_addr] <= {req_blue, req_green, req_red};
      end
   end

   assign rd_addr = cmd.search_step ? addr_ff : base_idx_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= pal_mem[rd_addr];
   end

   // Scale each channel: multiply by level, then divide by full light
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         prod_in[c]    = PROD_W'(rd_data_ff[c*CH_W +: CH_W]) * PROD_W'(level_ff);
         recip_prod[c] = MUL_W'(prod_ff[c]) * MUL_W'(DIV_MUL);
         target_in[c]  = CH_W'(recip_prod[c] >> DIV_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         base_idx_ff <= req_addr;
         level_ff    <= req_light_level;
      end
      if (cmd.scale_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.scale_div) begin
         target_ff <= target_in;
      end
   end

   // Largest channel difference against the entry just read
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (target_ff[c] > rd_data_ff[c*CH_W +: CH_W]) begin
            ch_diff[c] = target_ff[c] - rd_data_ff[c*CH_W +: CH_W];
         end else begin
            ch_diff[c] = rd_data_ff[c*CH_W +: CH_W] - target_ff[c];
         end
      end
      max_diff = ch_diff[0];
      if (ch_diff[1] > max_diff) begin
         max_diff = ch_diff[1];
      end
      if (ch_diff[2] > max_diff) begin
         max_diff = ch_diff[2];
      end
      cand_better = cmp_valid_ff && ({1'b0, max_diff} < best_diff_ff);
   end

   // Search address and compare pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.search_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         addr_ff <= '0;
      end else if (cmd.search_step) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
      cmp_idx_ff <= addr_ff;
   end

   // Track best entry; full light answers with the base index itself
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         best_diff_ff <= BEST_W'(1 << CH_W);
         best_idx_ff  <= '0;
      end else if (cmd.capture) begin
         best_idx_ff  <= req_addr;
      end else if (cand_better) begin
         best_diff_ff <= {1'b0, max_diff};
         best_idx_ff  <= cmp_idx_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_index_ff <= IDX_W'(best_idx_ff);
      end
   end

   assign rsp_nearest_index = rsp_index_ff;

endmodule

`default_nettype wire

// ===== hdl/lit_palette_nearest_color.sv =====
// Lit palette nearest-color search, top level.
// Depends on lpnc_pkg, lpnc_ctrl and lpnc_datapath.
//
// Usage:
//   req channel carries one item per transfer. req_tuser is the action:
//   0 loads a palette entry (entry_index, red, green, blue), 1 queries the
//   palette color nearest to the base entry entry_index scaled by
//   light_level/31. A load returns nothing; a query returns one item on the
//   rsp channel with nearest_index.
//   A load is written in the idle state and the next item may follow at once.
//   A query at light level 31 or above goes straight from idle to the done state.
//   Any other query reads the base entry, scales it in two registered
//   multiply stages, then walks the palette one entry per cycle through the
//   single read port of the palette memory; an exact match stops it early.
//   The finished result sits in an output register; while it waits for
//   rsp_tready the block already takes and works on the next item, and only
//   holds the following result until the register frees up.
//   Reset clears the control state and the result valid; palette contents are
//   undefined until loaded.
`default_nettype none

module lit_palette_nearest_color (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
   // [36:32] light_level, [39:37] zero
   input  wire logic [lpnc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] nearest_index
   output logic [lpnc_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import lpnc_pkg::*;

   lpnc_cmd_type    cmd;
   lpnc_status_type status;
   logic [IDX_W-1:0] nearest_index;

   lpnc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lpnc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_tuser),
      .req_entry_index   (req_tdata[7:0]),
      .req_red           (req_tdata[15:8]),
      .req_green         (req_tdata[23:16]),
      .req_blue          (req_tdata[31:24]),
      .req_light_level   (req_tdata[36:32]),
      .cmd               (cmd),
      .status            (status),
      .rsp_nearest_index (nearest_index)
   );

   assign rsp_tdata = RSP_DATA_W'(nearest_index);

   // Palette writes happen only on an accepted load transfer
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (req_tvalid && req_tready && !req_tuser))
      else $error("palette write without an accepted load");

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while pending");

   // A new result appears only after a load of the result register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.rsp_load))
      else $error("result valid raised without a load");

   // No new item is taken while the palette walk runs
   assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |-> !req_tready)
      else $error("input accepted during search");

endmodule

`default_nettype wire
